FILE: rtl/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared widths, curve breakpoints and segment spans for the flow to PWM
// duty curve.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam int FLOW_W        = 16;  // signed flow input width
    localparam int DUTY_W        = 7;   // duty result width
    localparam int FRAC_BITS_DEF = 8;   // default flow fraction bits
    localparam int CURVE_POINTS  = 11;
    localparam int SEGMENTS      = CURVE_POINTS - 1;
    localparam int SEG_W         = 4;   // segment index width
    localparam int HUND_W        = 12;  // breakpoints in hundredths fit here
    localparam int SPAN_W        = 10;  // widest segment span in hundredths
    localparam int SCALE_W       = 7;   // bits of the factor 100
    localparam int FLOW_SCALE    = 100;
    localparam int DUTY_STEP     = 10;
    localparam int DUTY_MAX      = 100;
    localparam int ROUND_SCALE   = 20;  // 2 * DUTY_STEP, for half-up rounding
    localparam int ROUND_W       = 5;

    // Calibration breakpoints in hundredths of a flow unit
    function automatic int curve_hundredths(input int idx);
        int val;
        case (idx)
            0:       val = 0;
            1:       val = 39;
            2:       val = 626;
            3:       val = 1045;
            4:       val = 1531;
            5:       val = 2028;
            6:       val = 2285;
            7:       val = 2595;
            8:       val = 2840;
            9:       val = 3014;
            10:      val = 3231;
            default: val = 3231;
        endcase
        return val;
    endfunction

    // Width of a segment in hundredths
    function automatic int seg_span(input int seg);
        return curve_hundredths(seg + 1) - curve_hundredths(seg);
    endfunction

endpackage

FILE: rtl/fpc_locate.sv
// ----------------------------------------------------------------------------
// fpc_locate
// Two pipeline stages: clamp and scale the flow by 100, then find its curve
// segment and the offset of the flow above the segment's lower breakpoint.
// ----------------------------------------------------------------------------
module fpc_locate #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [fpc_pkg::FLOW_W-1:0]      flow_fixed,
    output logic                                   seg_valid,
    input  logic                                   seg_ready,
    output logic                                   seg_sat,
    output logic [fpc_pkg::SEG_W-1:0]              seg_k,
    output logic [fpc_pkg::SPAN_W+FRAC_BITS-1:0]   seg_r
);
    import fpc_pkg::*;

    localparam int HW = FLOW_W - 1 + SCALE_W;
    localparam int BW = HUND_W + FRAC_BITS;
    localparam int CW = (HW > BW) ? HW : BW;
    localparam int RW = SPAN_W + FRAC_BITS;

    logic                 a_valid_reg;
    logic [CW-1:0]        a_h_reg;
    logic [CW-1:0]        a_h_next;
    logic                 a_ready;
    logic [FLOW_W-2:0]    flow_clamped;

    logic                 b_valid_reg;
    logic                 b_sat_reg;
    logic                 b_sat_next;
    logic [SEG_W-1:0]     b_k_reg;
    logic [SEG_W-1:0]     b_k_next;
    logic [RW-1:0]        b_r_reg;
    logic [RW-1:0]        b_r_next;
    logic [CW-1:0]        bp [CURVE_POINTS];

    // Stage A: clamp negative flow to zero, scale to hundredths
    assign a_ready  = !a_valid_reg || !b_valid_reg || seg_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        flow_clamped = flow_fixed[FLOW_W-1] ? '0 : flow_fixed[FLOW_W-2:0];
        a_h_next     = CW'(flow_clamped) * CW'(FLOW_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_h_reg <= a_h_next;
        end
    end

    // Stage B: compare against every breakpoint, pick segment and offset
    always_comb
    begin
        for (int i = 0; i < CURVE_POINTS; i++)
        begin
            bp[i] = CW'(curve_hundredths(i)) << FRAC_BITS;
        end
        b_k_next = '0;
        for (int i = 1; i < SEGMENTS; i++)
        begin
            if (a_h_reg >= bp[i])
            begin
                b_k_next = b_k_next + SEG_W'(1);
            end
        end
        b_sat_next = (a_h_reg >= bp[SEGMENTS]);
        b_r_next   = RW'(a_h_reg - bp[b_k_next]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (!b_valid_reg || seg_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && (!b_valid_reg || seg_ready))
        begin
            b_sat_reg <= b_sat_next;
            b_k_reg   <= b_k_next;
            b_r_reg   <= b_r_next;
        end
    end

    assign seg_valid = b_valid_reg;
    assign seg_sat   = b_sat_reg;
    assign seg_k     = b_k_reg;
    assign seg_r     = b_r_reg;

endmodule

FILE: rtl/fpc_interp.sv
// ----------------------------------------------------------------------------
// fpc_interp
// Output stage: interpolate inside the segment by comparing the scaled offset
// against the ten half-up rounding thresholds, and hold the duty item.
// ----------------------------------------------------------------------------
module fpc_interp #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   seg_valid,
    output logic                                   seg_ready,
    input  logic                                   seg_sat,
    input  logic [fpc_pkg::SEG_W-1:0]              seg_k,
    input  logic [fpc_pkg::SPAN_W+FRAC_BITS-1:0]   seg_r,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [fpc_pkg::DUTY_W-1:0]             duty
);
    import fpc_pkg::*;

    localparam int RW = SPAN_W + FRAC_BITS;
    localparam int TW = RW + ROUND_W;

    logic                 valid_reg;
    logic [DUTY_W-1:0]    duty_reg;
    logic [DUTY_W-1:0]    duty_next;
    logic [TW-1:0]        r_scaled;
    logic [TW-1:0]        thr;
    logic [SEG_W-1:0]     frac_step;
    logic                 load;

    assign seg_ready = !valid_reg || out_ready;
    assign load      = seg_valid && seg_ready;

    // Count thresholds (2j-1)*span*S passed by 20*r: the rounded tenth step
    always_comb
    begin
        r_scaled  = TW'(seg_r) * TW'(ROUND_SCALE);
        frac_step = '0;
        thr       = '0;
        for (int j = 1; j <= DUTY_STEP; j++)
        begin
            thr = TW'((2 * j - 1) * seg_span(int'(seg_k))) << FRAC_BITS;
            if (r_scaled >= thr)
            begin
                frac_step = frac_step + SEG_W'(1);
            end
        end
        if (seg_sat)
        begin
            duty_next = DUTY_W'(DUTY_MAX);
        end
        else
        begin
            duty_next = DUTY_W'(seg_k) * DUTY_W'(DUTY_STEP) + DUTY_W'(frac_step);
        end
    end

    // Hold the item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (seg_ready)
        begin
            valid_reg <= seg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            duty_reg <= duty_next;
        end
    end

    assign out_valid = valid_reg;
    assign duty      = duty_reg;

endmodule

FILE: rtl/flow_to_pwm_curve_core.sv
// ----------------------------------------------------------------------------
// flow_to_pwm_curve_core
// Maps a requested valve flow to a PWM duty of 0..100 on an eleven-point
// calibration curve, with linear interpolation and half-up rounding.
//
// Usage:
//   Input channel in_valid/in_ready carries flow_fixed, a signed fixed-point
//   flow with FRAC_BITS fraction bits; negative flow gives duty 0 and flow at
//   or above 32.31 gives duty 100. Output channel out_valid/out_ready carries
//   duty. Every item gives exactly one duty item, in order.
//   The accepting edge loads the scaled flow; the segment is then located
//   into stage B and interpolated into the output register. Throughput is
//   one item per cycle while out_ready is high; every stage has its own
//   valid bit, so empty stages fill while the output is stalled.
//   When out_ready is low the output register holds its item and the stages
//   behind it stop once full; in_ready falls only when all three hold items.
//   Reset clears all valid bits; nothing else needs to be set up.
// ----------------------------------------------------------------------------
module flow_to_pwm_curve_core #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [fpc_pkg::FLOW_W-1:0]  flow_fixed,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fpc_pkg::DUTY_W-1:0]         duty
);
    import fpc_pkg::*;

    logic                           seg_valid;
    logic                           seg_ready;
    logic                           seg_sat;
    logic [SEG_W-1:0]               seg_k;
    logic [SPAN_W+FRAC_BITS-1:0]    seg_r;

    // Scale and segment search
    fpc_locate #(
        .FRAC_BITS (FRAC_BITS)
    ) u_locate (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .flow_fixed (flow_fixed),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg_sat    (seg_sat),
        .seg_k      (seg_k),
        .seg_r      (seg_r)
    );

    // Interpolation and output register
    fpc_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg_sat    (seg_sat),
        .seg_k      (seg_k),
        .seg_r      (seg_r),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .duty       (duty)
    );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks flow_to_pwm_curve_core: drives signed flow items through valid/ready,
// predicts every duty from the calibration curve with exact integer math,
// and compares each duty item in order, under random gaps, random stalls and
// one long output hold that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import fpc_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int PIPE_LATENCY = 3;
    localparam int GAP_MAX      = 13;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [FLOW_W-1:0] flow_fixed = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [DUTY_W-1:0]        duty;

    // Calibration breakpoints in hundredths of a flow unit
    int unsigned curve_bp [CURVE_POINTS] =
        '{0, 39, 626, 1045, 1531, 2028, 2285, 2595, 2840, 3014, 3231};

    logic [DUTY_W-1:0] duty_expected [$];
    logic [DUTY_W-1:0] duty_want;
    int                in_gap_max   = GAP_MAX;
    int                out_gap_max  = GAP_MAX;
    int                hold_request = 0;
    int                hold_left    = 0;
    int                stall_left   = 0;
    int                stall_draw   = 0;
    bit                out_taken    = 1'b0;
    int                cycle_count  = 0;
    int                errors       = 0;
    int                flows_sent   = 0;
    int                duties_seen  = 0;
    int                duty_low     = 0;
    int                duty_high    = 0;

    flow_to_pwm_curve_core #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .flow_fixed(flow_fixed),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .duty      (duty)
    );

    always #1 clk = ~clk;

    // Compute duty for one flow: clamp, find segment, interpolate, round half up
    function automatic logic [DUTY_W-1:0] predict_duty(input logic signed [FLOW_W-1:0] f);
        longint unsigned x;
        longint unsigned h;
        longint unsigned b0;
        longint unsigned b1;
        longint unsigned d;
        longint unsigned n;
        longint unsigned num;
        longint unsigned seg;
        x   = f[FLOW_W-1] ? 64'd0 : {48'd0, f};
        h   = 100 * x;
        seg = 0;
        if (h >= (longint'(curve_bp[CURVE_POINTS-1]) << FRAC))
            return DUTY_W'(DUTY_MAX);
        for (int i = 1; i < CURVE_POINTS - 1; i++)
        begin
            if (h >= (longint'(curve_bp[i]) << FRAC))
                seg = i;
        end
        b0  = longint'(curve_bp[seg]) << FRAC;
        b1  = longint'(curve_bp[seg + 1]) << FRAC;
        d   = b1 - b0;
        n   = 10 * (b1 - h);
        num = 20 * (seg + 1) * d + d - 2 * n;
        return DUTY_W'(num / (2 * d));
    endfunction

    // Record accepted flows and check each accepted duty against the oldest one
    always @(posedge clk)
    begin
        out_taken = 1'b0;
        if (rst_n)
        begin
            cycle_count++;
            if (in_valid && in_ready)
            begin
                duty_expected.push_back(predict_duty(flow_fixed));
                flows_sent++;
            end
            if (out_valid && out_ready)
            begin
                out_taken = 1'b1;
                duties_seen++;
                if (duty == 0)
                    duty_low++;
                if (duty == DUTY_MAX)
                    duty_high++;
                if (duty_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: duty item %0d with none expected", $time, duty);
                end
                else
                begin
                    duty_want = duty_expected.pop_front();
                    if (duty !== duty_want)
                    begin
                        errors++;
                        $display("%0t: duty mismatch, expected %0d, actual %0d",
                                 $time, duty_want, duty);
                    end
                end
            end
        end
    end

    // Drive out_ready: long hold on request, else a random stall per duty item
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_request > 0)
        begin
            hold_left    <= hold_request - 1;
            hold_request <= 0;
            out_ready    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (out_taken && out_gap_max > 0)
        begin
            stall_draw = $urandom_range(out_gap_max, 0);
            stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
            out_ready  <= (stall_draw == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL flow_to_pwm_curve_core");
        $finish;
    end

    // Offer one flow item after a random gap and hold it until accepted
    task automatic send_flow(input logic signed [FLOW_W-1:0] f);
        int gap;
        gap = (in_gap_max > 0) ? $urandom_range(in_gap_max, 0) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        flow_fixed <= f;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every expected duty has come back
    task automatic drain_duties();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (duty_expected.size() == 0);
    endtask

    // Clamp extremes, zero, and both sides of every breakpoint
    task automatic test_curve_edges();
        int unsigned below;
        send_flow(-16'sd32768);
        send_flow(-16'sd1);
        send_flow(16'sd32767);
        send_flow(16'sd0);
        send_flow(16'sd1);
        for (int k = 1; k < CURVE_POINTS; k++)
        begin
            below = (curve_bp[k] << FRAC) / FLOW_SCALE;
            send_flow(FLOW_W'(below));
            send_flow(FLOW_W'(below + 1));
        end
        drain_duties();
    endtask

    // Any 16-bit pattern, so every input bit toggles and both clamps are hit
    task automatic test_full_range(input int count);
        for (int i = 0; i < count; i++)
            send_flow(FLOW_W'($urandom));
        drain_duties();
    endtask

    // Flows spread over the curve and slightly past its top
    task automatic test_curve_interior(input int count);
        for (int i = 0; i < count; i++)
            send_flow(FLOW_W'($urandom_range(8400, 0)));
        drain_duties();
    endtask

    // Flows within a few steps of a breakpoint
    task automatic test_near_breakpoints(input int count);
        int k;
        int base;
        for (int i = 0; i < count; i++)
        begin
            k    = $urandom_range(CURVE_POINTS - 1, 1);
            base = (curve_bp[k] << FRAC) / FLOW_SCALE;
            send_flow(FLOW_W'(base + $urandom_range(6, 0) - 3));
        end
        drain_duties();
    endtask

    // Full rate on both sides, no idle cycles
    task automatic test_back_to_back(input int count);
        in_gap_max  = 0;
        out_gap_max = 0;
        for (int i = 0; i < count; i++)
            send_flow(FLOW_W'($urandom_range(8400, 0)));
        drain_duties();
        in_gap_max  = GAP_MAX;
        out_gap_max = GAP_MAX;
    endtask

    // Hold the output long enough that the pipeline fills and stalls the input
    task automatic test_output_hold(input int count);
        in_gap_max = 0;
        @(negedge clk);
        hold_request = LONG_HOLD;
        for (int i = 0; i < count; i++)
            send_flow(FLOW_W'($urandom));
        drain_duties();
        in_gap_max = GAP_MAX;
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_curve_edges();
        test_full_range(300);
        test_curve_interior(700);
        test_near_breakpoints(150);
        test_back_to_back(200);
        test_output_hold(100);

        // Let any stray duty item show up before judging
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        $display("Sent %0d flow items and checked %0d duty items in %0d cycles",
                 flows_sent, duties_seen, cycle_count);
        $display("Duty at 0: %0d, at full scale: %0d, interpolated: %0d",
                 duty_low, duty_high, duties_seen - duty_low - duty_high);
        if (errors == 0)
            $display("PASS flow_to_pwm_curve_core");
        else
            $display("FAIL flow_to_pwm_curve_core");
        $finish;
    end

endmodule

FILE: flow_to_pwm_curve_core.f
rtl/fpc_pkg.sv
rtl/fpc_locate.sv
rtl/fpc_interp.sv
rtl/flow_to_pwm_curve_core.sv
tb/testbench.sv
